// ----- design/barcode_demultiplexer_assert.svh -----
// assertion macros used by the top-level rtl file
`ifndef BARCODE_DEMULTIPLEXER_ASSERT_SVH
`define BARCODE_DEMULTIPLEXER_ASSERT_SVH

`ifndef SYNTH
// plain property check on clk_i, off during reset
`define BCD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// implication check on clk_i, off during reset
`define BCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define BCD_ASSERT(label, prop)
`define BCD_ASSERT_IMP(label, ante, cons)
`endif

`endif

// ----- design/bcd_pkg.sv -----
package bcd_pkg;

  localparam int MaxBarcodes = 16;
  localparam int MaxTagLen   = 7;
  localparam int BaseW       = 3;
  localparam int TagW        = MaxTagLen * BaseW;
  localparam int LenW        = 3;
  localparam int NumBins     = MaxBarcodes + 1;
  localparam int BinW        = $clog2(NumBins);
  localparam int EntryW      = $clog2(MaxBarcodes);
  localparam int DistW       = $clog2(MaxTagLen + 1);
  localparam int CountW      = 32;
  localparam int BcntW       = 5;
  localparam int LimitW      = 3;
  localparam int ModeW       = 2;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 5;
  localparam int InDataW     = 56;
  localparam int OutDataW    = 40;

  localparam logic [BinW-1:0] UnmatchedBin = BinW'(MaxBarcodes);

  localparam logic [CfgIdxW-1:0] CfgMismatchLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBarcodeCount  = 1'b1;

  typedef logic [TagW-1:0] tag_t;
  typedef logic [LenW-1:0] len_t;

  typedef enum logic [ModeW-1:0] {
    ModeLoad     = 2'd0,
    ModeClassify = 2'd1,
    ModeQuery    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    StIdle,
    StMatch,
    StUpdate
  } state_e;

  typedef struct packed {
    logic            hit;
    logic [BinW-1:0] bin;
    len_t            trim;
  } match_t;

endpackage

// ----- design/bcd_match.sv -----
module bcd_match (
  input  bcd_pkg::tag_t [bcd_pkg::MaxBarcodes-1:0] tags_i,
  input  bcd_pkg::len_t [bcd_pkg::MaxBarcodes-1:0] lens_i,
  input  bcd_pkg::tag_t                            read_i,
  input  logic [bcd_pkg::LimitW-1:0]               limit_i,
  input  logic [bcd_pkg::BcntW-1:0]                count_i,
  output bcd_pkg::match_t                          match_o
);

  logic [bcd_pkg::BcntW-1:0]       active_n;
  logic [bcd_pkg::MaxBarcodes-1:0] entry_ok;

  assign active_n = (count_i > bcd_pkg::BcntW'(bcd_pkg::MaxBarcodes)) ?
                    bcd_pkg::BcntW'(bcd_pkg::MaxBarcodes) : count_i;

  // per-entry hamming distance over the tag's own length
  always_comb begin
    logic [bcd_pkg::DistW-1:0] ham_dist;
    for (int e = 0; e < bcd_pkg::MaxBarcodes; e++) begin
      ham_dist = '0;
      for (int b = 0; b < bcd_pkg::MaxTagLen; b++) begin
        if ((bcd_pkg::LenW'(b) < lens_i[e]) &&
            (tags_i[e][b*bcd_pkg::BaseW +: bcd_pkg::BaseW] !=
             read_i[b*bcd_pkg::BaseW +: bcd_pkg::BaseW])) begin
          ham_dist = ham_dist + bcd_pkg::DistW'(1);
        end
      end
      entry_ok[e] = (bcd_pkg::BcntW'(e) < active_n) && (ham_dist <= limit_i);
    end
  end

  // lowest index wins
  always_comb begin
    match_o.hit  = 1'b0;
    match_o.bin  = bcd_pkg::UnmatchedBin;
    match_o.trim = '0;
    for (int e = bcd_pkg::MaxBarcodes - 1; e >= 0; e--) begin
      if (entry_ok[e]) begin
        match_o.hit  = 1'b1;
        match_o.bin  = bcd_pkg::BinW'(e);
        match_o.trim = lens_i[e];
      end
    end
  end

endmodule

// ----- design/barcode_demultiplexer.sv -----
// items: a new item is taken only in idle, after the match / count read /
//   count write-back sequence of the last one around the count memory
// reset: async active low; clears control, config (limit 1, count 0) and the
//   count valid bits, so every bin reads zero; the tag table is not cleared
`include "barcode_demultiplexer_assert.svh"

module barcode_demultiplexer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bcd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bcd_pkg::CfgDataW-1:0]     cfg_data_i,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_index[4:0], tag_bases[25:5], tag_length[28:26], read_bases[49:29], zero pad
  input  logic [bcd_pkg::InDataW-1:0]      s_axis_tdata,
  // mode[1:0]
  input  logic [bcd_pkg::ModeW-1:0]        s_axis_tuser,
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // bin[4:0], trim_length[7:5], bin_count[39:8]
  output logic [bcd_pkg::OutDataW-1:0]     m_axis_tdata
);

  // ---------------------------------------------------------------------------
  // input unpacking
  // ---------------------------------------------------------------------------
  logic                     in_fire;
  bcd_pkg::mode_e           in_mode;
  logic [bcd_pkg::BinW-1:0] in_idx;
  bcd_pkg::tag_t            in_tag;
  bcd_pkg::len_t            in_len;
  bcd_pkg::tag_t            in_read;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_mode = bcd_pkg::mode_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[4:0];
  assign in_tag  = s_axis_tdata[25:5];
  assign in_len  = s_axis_tdata[28:26];
  assign in_read = s_axis_tdata[49:29];

  // ---------------------------------------------------------------------------
  // configuration registers, writes taken at any time
  // ---------------------------------------------------------------------------
  logic [bcd_pkg::LimitW-1:0] mismatch_limit_q;
  logic [bcd_pkg::BcntW-1:0]  barcode_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatch_limit_q <= bcd_pkg::LimitW'(1);
      barcode_count_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bcd_pkg::CfgMismatchLimit: mismatch_limit_q <= cfg_data_i[bcd_pkg::LimitW-1:0];
        bcd_pkg::CfgBarcodeCount:  barcode_count_q  <= cfg_data_i[bcd_pkg::BcntW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // barcode tag table: written on load, every entry compared in parallel
  // ---------------------------------------------------------------------------
  bcd_pkg::tag_t [bcd_pkg::MaxBarcodes-1:0] tags_q;
  bcd_pkg::len_t [bcd_pkg::MaxBarcodes-1:0] lens_q;

  // tag_length is 3 bits, so it never exceeds the longest tag
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_mode == bcd_pkg::ModeLoad) && (in_idx < bcd_pkg::UnmatchedBin)) begin
      tags_q[in_idx[bcd_pkg::EntryW-1:0]] <= in_tag;
      lens_q[in_idx[bcd_pkg::EntryW-1:0]] <= in_len;
    end
  end

  // ---------------------------------------------------------------------------
  // item registers, captured on accept
  // ---------------------------------------------------------------------------
  bcd_pkg::mode_e           mode_q;
  logic [bcd_pkg::BinW-1:0] idx_q;
  bcd_pkg::tag_t            read_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= in_mode;
      idx_q  <= in_idx;
      read_q <= in_read;
    end
  end

  // ---------------------------------------------------------------------------
  // match against the table (uses the item registered on accept)
  // ---------------------------------------------------------------------------
  bcd_pkg::match_t match;

  bcd_match u_match (
    .tags_i  (tags_q),
    .lens_i  (lens_q),
    .read_i  (read_q),
    .limit_i (mismatch_limit_q),
    .count_i (barcode_count_q),
    .match_o (match)
  );

  // ---------------------------------------------------------------------------
  // sequencer: idle -> match (issue count read) -> update (write back, emit)
  // ---------------------------------------------------------------------------
  bcd_pkg::state_e state_q, state_d;
  logic            rd_en;
  logic            mem_we;
  logic            out_load;
  logic            addr_ok;
  logic [bcd_pkg::BinW-1:0] rd_addr;

  // classify reads the chosen bin, query reads the requested one if it exists
  assign rd_addr = (mode_q == bcd_pkg::ModeClassify) ? match.bin : idx_q;
  assign addr_ok = (mode_q == bcd_pkg::ModeClassify) ||
                   ((mode_q == bcd_pkg::ModeQuery) && (idx_q <= bcd_pkg::UnmatchedBin));

  always_comb begin
    state_d  = state_q;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      bcd_pkg::StIdle: begin
        if (in_fire) state_d = bcd_pkg::StMatch;
      end
      bcd_pkg::StMatch: begin
        rd_en   = addr_ok;
        state_d = bcd_pkg::StUpdate;
      end
      bcd_pkg::StUpdate: begin
        // wait here while the output register still holds an untaken item
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          mem_we   = (mode_q == bcd_pkg::ModeClassify);
          state_d  = bcd_pkg::StIdle;
        end
      end
      default: state_d = bcd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == bcd_pkg::StIdle);

  // match result held for the update cycle
  logic [bcd_pkg::BinW-1:0] res_bin_q;
  bcd_pkg::len_t            res_trim_q;
  logic                     addr_ok_q;

  always_ff @(posedge clk_i) begin
    if (state_q == bcd_pkg::StMatch) begin
      res_bin_q  <= match.bin;
      res_trim_q <= match.trim;
      addr_ok_q  <= addr_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // per-bin read counts: one synchronous memory, read-modify-write
  // a bin never written since reset reads as zero through its valid bit
  // ---------------------------------------------------------------------------
  logic [bcd_pkg::CountW-1:0]  cnt_mem [bcd_pkg::NumBins];
  logic [bcd_pkg::CountW-1:0]  rd_data_q;
  logic [bcd_pkg::NumBins-1:0] cnt_vld_q;
  logic                        rd_vld_q;
  logic [bcd_pkg::CountW-1:0]  cur_cnt;
  logic [bcd_pkg::CountW-1:0]  inc_cnt;

  always_ff @(posedge clk_i) begin
    if (mem_we) cnt_mem[res_bin_q] <= inc_cnt;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) cnt_vld_q[res_bin_q] <= 1'b1;
      if (rd_en)  rd_vld_q <= cnt_vld_q[rd_addr];
    end
  end

  // saturating increment
  assign cur_cnt = (addr_ok_q && rd_vld_q) ? rd_data_q : '0;
  assign inc_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + bcd_pkg::CountW'(1);

  // ---------------------------------------------------------------------------
  // result assembly and output register
  // ---------------------------------------------------------------------------
  logic [bcd_pkg::BinW-1:0]   out_bin;
  bcd_pkg::len_t              out_trim;
  logic [bcd_pkg::CountW-1:0] out_cnt;
  logic                       m_tvalid_q;
  logic [bcd_pkg::OutDataW-1:0] m_tdata_q;

  always_comb begin
    out_bin  = idx_q;
    out_trim = '0;
    out_cnt  = '0;
    case (mode_q)
      bcd_pkg::ModeClassify: begin
        out_bin  = res_bin_q;
        out_trim = res_trim_q;
        out_cnt  = inc_cnt;
      end
      bcd_pkg::ModeQuery: out_cnt = cur_cnt;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_tdata_q <= {out_cnt, out_trim, out_bin};
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `BCD_ASSERT_IMP(a_accept_to_match, in_fire, ##1 (state_q == bcd_pkg::StMatch))
  `BCD_ASSERT_IMP(a_match_to_update, state_q == bcd_pkg::StMatch, ##1 (state_q == bcd_pkg::StUpdate))
  `BCD_ASSERT_IMP(a_out_from_update, $rose(m_axis_tvalid), $past(state_q) == bcd_pkg::StUpdate)
  `BCD_ASSERT_IMP(a_count_never_wraps, mem_we, inc_cnt != '0)
  `BCD_ASSERT_IMP(a_hit_in_table, match.hit, match.bin < bcd_pkg::UnmatchedBin)

endmodule
